// ----- rtl/tevq_pkg.sv -----
package tevq_pkg;

   // default sizes
   localparam int DEPTH_DEFAULT         = 256;
   localparam int BURST_DEFAULT         = 16;
   localparam int PAYLOAD_WIDTH_DEFAULT = 32;

   // fixed field widths of the channels
   localparam int KIND_W    = 2;
   localparam int TIME_W    = 32;
   localparam int PAYLOAD_W = 32;
   localparam int STATUS_W  = 2;
   localparam int SLOT_OUT_W = 8;

   // request codes
   localparam logic REQ_ADD    = 1'b0;
   localparam logic REQ_UPDATE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_ADDED   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EXPIRED = 2'd2;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WALK_START,
      ST_WALK_CHK,
      ST_LINK,
      ST_LINK_PREV,
      ST_POP_READ,
      ST_POP_CHK,
      ST_FLUSH
   } state_type;

   // operations of the shared comparator
   typedef enum logic {
      CMP_INSERT,
      CMP_EXPIRE
   } cmp_op_type;

endpackage

// ----- rtl/tevq_if.sv -----
// request channel
interface tevq_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [tevq_pkg::KIND_W-1:0]    event_kind;
   logic [tevq_pkg::TIME_W-1:0]    expiry_time;
   logic [tevq_pkg::PAYLOAD_W-1:0] payload;
   logic [tevq_pkg::TIME_W-1:0]    now;

   modport source (output valid, req_type, event_kind, expiry_time, payload, now,
                   input ready);
   modport sink   (input valid, req_type, event_kind, expiry_time, payload, now,
                   output ready);
endinterface

// response channel
interface tevq_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [tevq_pkg::STATUS_W-1:0]   status;
   logic [tevq_pkg::SLOT_OUT_W-1:0] slot;
   logic [tevq_pkg::KIND_W-1:0]     event_kind_out;
   logic [tevq_pkg::TIME_W-1:0]     expiry_out;
   logic [tevq_pkg::PAYLOAD_W-1:0]  payload_out;
   logic                           last;

   modport source (output valid, status, slot, event_kind_out, expiry_out, payload_out,
                   last, input ready);
   modport sink   (input valid, status, slot, event_kind_out, expiry_out, payload_out,
                   last, output ready);
endinterface

// ----- rtl/tevq_cmp.sv -----
module tevq_cmp (
   input  tevq_pkg::cmp_op_type        op,
   input  logic [tevq_pkg::TIME_W-1:0] key,
   input  logic [tevq_pkg::TIME_W-1:0] now,
   input  logic [tevq_pkg::TIME_W-1:0] stored,
   output logic                        hit
);

   logic [tevq_pkg::TIME_W-1:0] lhs;
   logic [tevq_pkg::TIME_W-1:0] rhs;

   // insert: new expiry at or before stored; expire: stored at or before now
   always_comb begin
      unique case (op)
         tevq_pkg::CMP_INSERT: begin
            lhs = key;
            rhs = stored;
         end
         tevq_pkg::CMP_EXPIRE: begin
            lhs = stored;
            rhs = now;
         end
         default: begin
            lhs = key;
            rhs = stored;
         end
      endcase
   end

   // one unsigned compare shared by both walks
   assign hit = (lhs <= rhs);

endmodule

// ----- rtl/tevq_used_map.sv -----
module tevq_used_map #(
   parameter int DEPTH = tevq_pkg::DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     set_en,
   input  logic [$clog2(DEPTH)-1:0] set_idx,
   input  logic                     clr_en,
   input  logic [$clog2(DEPTH)-1:0] clr_idx,
   input  logic [$clog2(DEPTH)-1:0] rd_idx,
   output logic                     rd_used
);

   logic [DEPTH-1:0] used_ff;
   logic [DEPTH-1:0] used_in;

   // occupancy update
   always_comb begin
      used_in = used_ff;
      if (clr_en) begin
         used_in[clr_idx] = 1'b0;
      end
      if (set_en) begin
         used_in[set_idx] = 1'b1;
      end
   end

   // every slot free after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   assign rd_used = used_ff[rd_idx];

endmodule

// ----- rtl/tevq_store.sv -----
module tevq_store #(
   parameter int DEPTH  = tevq_pkg::DEPTH_DEFAULT,
   parameter int DATA_W = 66
) (
   input  logic                     clock,
   input  logic                     data_we,
   input  logic [$clog2(DEPTH)-1:0] data_addr,
   input  logic [DATA_W-1:0]        data_wr,
   input  logic                     next_we,
   input  logic [$clog2(DEPTH)-1:0] next_addr,
   input  logic [$clog2(DEPTH)-1:0] next_wr,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data,
   output logic [$clog2(DEPTH)-1:0] rd_next
);

   localparam int SLOT_W = $clog2(DEPTH);

   logic [DATA_W-1:0] data_mem_ff [DEPTH];
   logic [SLOT_W-1:0] next_mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic [SLOT_W-1:0] rd_next_ff;

   // entry fields: kind, expiry, payload
   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem_ff[data_addr] <= data_wr;
      end
      rd_data_ff <= data_mem_ff[rd_addr];
   end

   // list links
   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem_ff[next_addr] <= next_wr;
      end
      rd_next_ff <= next_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign rd_next = rd_next_ff;

endmodule

// ----- rtl/timed_event_queue.sv -----
// Sorted timer event queue. Events live in DEPTH slots of a memory, linked into one
// list in ascending expiry order; a new event goes ahead of entries with the same
// expiry. An add (req_type 0) answers with one item: the slot taken (lowest free
// slot) or queue full. An update (req_type 1) pops expired events from the head, at
// most BURST of them, the final one marked last; with nothing expired it gives no
// item. One request is handled at a time and ready is low meanwhile. An add scans
// for a free slot (one occupancy bit per cycle), then walks the list (one memory
// read and one compare per entry, one entry per cycle), then links the entry; a full
// queue answers without a scan. An update reads and then compares each popped event,
// and is held while the response side stalls. No clearing pass follows reset.
module timed_event_queue #(
   parameter int DEPTH         = tevq_pkg::DEPTH_DEFAULT,
   parameter int BURST         = tevq_pkg::BURST_DEFAULT,
   parameter int PAYLOAD_WIDTH = tevq_pkg::PAYLOAD_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   tevq_req_if.sink          req_chan,
   tevq_rsp_if.source        rsp_chan
);

   localparam int SLOT_W   = $clog2(DEPTH);
   localparam int COUNT_W  = $clog2(DEPTH + 1);
   localparam int BURST_W  = $clog2(BURST + 1);
   localparam int STORE_PW = (PAYLOAD_WIDTH < tevq_pkg::PAYLOAD_W) ?
                             PAYLOAD_WIDTH : tevq_pkg::PAYLOAD_W;
   localparam int DATA_W   = tevq_pkg::KIND_W + tevq_pkg::TIME_W + STORE_PW;

   // sequencer and list state
   tevq_pkg::state_type state_ff, state_in;
   logic [SLOT_W-1:0]   head_ff, head_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [SLOT_W-1:0]   scan_ff, scan_in;
   logic [SLOT_W-1:0]   free_ff, free_in;
   logic [SLOT_W-1:0]   cur_ff, cur_in;
   logic [SLOT_W-1:0]   prev_ff, prev_in;
   logic                have_prev_ff, have_prev_in;
   logic [COUNT_W-1:0]  walk_ff, walk_in;
   logic [BURST_W-1:0]  burst_ff, burst_in;
   logic                pend_valid_ff, pend_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // request item fields
   logic [tevq_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [tevq_pkg::TIME_W-1:0] expiry_ff, expiry_in;
   logic [STORE_PW-1:0]         payload_ff, payload_in;
   logic [tevq_pkg::TIME_W-1:0] now_ff, now_in;

   // pending item, held until it is known whether it is the last
   logic [tevq_pkg::STATUS_W-1:0] pend_status_ff, pend_status_in;
   logic [SLOT_W-1:0]             pend_slot_ff, pend_slot_in;
   logic [tevq_pkg::KIND_W-1:0]   pend_kind_ff, pend_kind_in;
   logic [tevq_pkg::TIME_W-1:0]   pend_expiry_ff, pend_expiry_in;
   logic [STORE_PW-1:0]           pend_payload_ff, pend_payload_in;

   // output register
   logic [tevq_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [tevq_pkg::SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [tevq_pkg::KIND_W-1:0]     rsp_kind_ff, rsp_kind_in;
   logic [tevq_pkg::TIME_W-1:0]     rsp_expiry_ff, rsp_expiry_in;
   logic [tevq_pkg::PAYLOAD_W-1:0]  rsp_payload_ff, rsp_payload_in;
   logic                            rsp_last_ff, rsp_last_in;

   // store, occupancy map and comparator hookup
   logic                        data_we;
   logic [SLOT_W-1:0]           data_addr;
   logic [DATA_W-1:0]           data_wr;
   logic                        next_we;
   logic [SLOT_W-1:0]           next_addr;
   logic [SLOT_W-1:0]           next_wr;
   logic [SLOT_W-1:0]           rd_addr;
   logic [DATA_W-1:0]           rd_data;
   logic [SLOT_W-1:0]           rd_next;
   logic                        used_set;
   logic                        used_clr;
   logic                        rd_used;
   tevq_pkg::cmp_op_type        cmp_op;
   logic                        cmp_hit;
   logic [tevq_pkg::KIND_W-1:0] rd_kind;
   logic [tevq_pkg::TIME_W-1:0] rd_expiry;
   logic [STORE_PW-1:0]         rd_payload;
   logic                        rsp_free;
   logic                        pop_fire;
   logic [COUNT_W-1:0]          walk_nxt;

   assign rd_kind    = rd_data[DATA_W-1 -: tevq_pkg::KIND_W];
   assign rd_expiry  = rd_data[STORE_PW +: tevq_pkg::TIME_W];
   assign rd_payload = rd_data[STORE_PW-1:0];
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;
   assign walk_nxt   = walk_ff + COUNT_W'(1);

   tevq_store #(
      .DEPTH  (DEPTH),
      .DATA_W (DATA_W)
   ) u_store (
      .clock     (clock),
      .data_we   (data_we),
      .data_addr (data_addr),
      .data_wr   (data_wr),
      .next_we   (next_we),
      .next_addr (next_addr),
      .next_wr   (next_wr),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rd_next   (rd_next)
   );

   tevq_used_map #(
      .DEPTH (DEPTH)
   ) u_used_map (
      .clock   (clock),
      .reset   (reset),
      .set_en  (used_set),
      .set_idx (free_ff),
      .clr_en  (used_clr),
      .clr_idx (head_ff),
      .rd_idx  (scan_ff),
      .rd_used (rd_used)
   );

   tevq_cmp u_cmp (
      .op     (cmp_op),
      .key    (expiry_ff),
      .now    (now_ff),
      .stored (rd_expiry),
      .hit    (cmp_hit)
   );

   // sequencer: next state and datapath control
   always_comb begin
      state_in        = state_ff;
      head_in         = head_ff;
      count_in        = count_ff;
      scan_in         = scan_ff;
      free_in         = free_ff;
      cur_in          = cur_ff;
      prev_in         = prev_ff;
      have_prev_in    = have_prev_ff;
      walk_in         = walk_ff;
      burst_in        = burst_ff;
      pend_valid_in   = pend_valid_ff;
      kind_in         = kind_ff;
      expiry_in       = expiry_ff;
      payload_in      = payload_ff;
      now_in          = now_ff;
      pend_status_in  = pend_status_ff;
      pend_slot_in    = pend_slot_ff;
      pend_kind_in    = pend_kind_ff;
      pend_expiry_in  = pend_expiry_ff;
      pend_payload_in = pend_payload_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in   = rsp_status_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_kind_in     = rsp_kind_ff;
      rsp_expiry_in   = rsp_expiry_ff;
      rsp_payload_in  = rsp_payload_ff;
      rsp_last_in     = rsp_last_ff;
      data_we         = 1'b0;
      data_addr       = free_ff;
      data_wr         = {kind_ff, expiry_ff, payload_ff};
      next_we         = 1'b0;
      next_addr       = free_ff;
      next_wr         = cur_ff;
      rd_addr         = head_ff;
      used_set        = 1'b0;
      used_clr        = 1'b0;
      cmp_op          = tevq_pkg::CMP_INSERT;
      pop_fire        = 1'b0;
      req_chan.ready  = 1'b0;

      unique case (state_ff)
         // take a request
         tevq_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               kind_in       = req_chan.event_kind;
               expiry_in     = req_chan.expiry_time;
               payload_in    = req_chan.payload[STORE_PW-1:0];
               now_in        = req_chan.now;
               pend_valid_in = 1'b0;
               if (req_chan.req_type == tevq_pkg::REQ_ADD) begin
                  if (count_ff == COUNT_W'(DEPTH)) begin
                     pend_valid_in   = 1'b1;
                     pend_status_in  = tevq_pkg::STATUS_FULL;
                     pend_slot_in    = '0;
                     pend_kind_in    = '0;
                     pend_expiry_in  = '0;
                     pend_payload_in = '0;
                     state_in        = tevq_pkg::ST_FLUSH;
                  end else begin
                     scan_in  = '0;
                     state_in = tevq_pkg::ST_SCAN;
                  end
               end else begin
                  burst_in = '0;
                  state_in = tevq_pkg::ST_POP_READ;
               end
            end
         end

         // lowest free slot, one bit per cycle
         tevq_pkg::ST_SCAN: begin
            if (!rd_used) begin
               free_in      = scan_ff;
               cur_in       = head_ff;
               have_prev_in = 1'b0;
               walk_in      = '0;
               state_in     = tevq_pkg::ST_WALK_START;
            end else begin
               scan_in = scan_ff + SLOT_W'(1);
            end
         end

         // start the sorted walk
         tevq_pkg::ST_WALK_START: begin
            if (walk_ff == count_ff) begin
               state_in = tevq_pkg::ST_LINK;
            end else begin
               rd_addr  = cur_ff;
               state_in = tevq_pkg::ST_WALK_CHK;
            end
         end

         // one entry per cycle; the link read feeds the next address
         tevq_pkg::ST_WALK_CHK: begin
            cmp_op = tevq_pkg::CMP_INSERT;
            if (cmp_hit) begin
               state_in = tevq_pkg::ST_LINK;
            end else begin
               prev_in      = cur_ff;
               have_prev_in = 1'b1;
               cur_in       = rd_next;
               walk_in      = walk_nxt;
               rd_addr      = rd_next;
               if (walk_nxt == count_ff) begin
                  state_in = tevq_pkg::ST_LINK;
               end
            end
         end

         // store the new entry, pointing at the walk position
         tevq_pkg::ST_LINK: begin
            data_we         = 1'b1;
            next_we         = 1'b1;
            next_addr       = free_ff;
            next_wr         = cur_ff;
            used_set        = 1'b1;
            count_in        = count_ff + COUNT_W'(1);
            pend_valid_in   = 1'b1;
            pend_status_in  = tevq_pkg::STATUS_ADDED;
            pend_slot_in    = free_ff;
            pend_kind_in    = '0;
            pend_expiry_in  = '0;
            pend_payload_in = '0;
            if (have_prev_ff) begin
               state_in = tevq_pkg::ST_LINK_PREV;
            end else begin
               head_in  = free_ff;
               state_in = tevq_pkg::ST_FLUSH;
            end
         end

         // splice after the predecessor
         tevq_pkg::ST_LINK_PREV: begin
            next_we   = 1'b1;
            next_addr = prev_ff;
            next_wr   = free_ff;
            state_in  = tevq_pkg::ST_FLUSH;
         end

         // read the head if the list is not empty and the burst allows
         tevq_pkg::ST_POP_READ: begin
            if ((count_ff == '0) || (burst_ff == BURST_W'(BURST))) begin
               state_in = tevq_pkg::ST_FLUSH;
            end else begin
               rd_addr  = head_ff;
               state_in = tevq_pkg::ST_POP_CHK;
            end
         end

         // pop an expired head; the previous pop goes out as not last
         tevq_pkg::ST_POP_CHK: begin
            rd_addr = head_ff;
            cmp_op  = tevq_pkg::CMP_EXPIRE;
            if (!cmp_hit) begin
               state_in = tevq_pkg::ST_FLUSH;
            end else if (!pend_valid_ff || rsp_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in   = 1'b1;
                  rsp_status_in  = pend_status_ff;
                  rsp_slot_in    = tevq_pkg::SLOT_OUT_W'(pend_slot_ff);
                  rsp_kind_in    = pend_kind_ff;
                  rsp_expiry_in  = pend_expiry_ff;
                  rsp_payload_in = tevq_pkg::PAYLOAD_W'(pend_payload_ff);
                  rsp_last_in    = 1'b0;
               end
               pop_fire        = 1'b1;
               pend_valid_in   = 1'b1;
               pend_status_in  = tevq_pkg::STATUS_EXPIRED;
               pend_slot_in    = head_ff;
               pend_kind_in    = rd_kind;
               pend_expiry_in  = rd_expiry;
               pend_payload_in = rd_payload;
               used_clr        = 1'b1;
               head_in         = rd_next;
               count_in        = count_ff - COUNT_W'(1);
               burst_in        = burst_ff + BURST_W'(1);
               state_in        = tevq_pkg::ST_POP_READ;
            end
         end

         // final item of the request, marked last
         tevq_pkg::ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = tevq_pkg::ST_IDLE;
            end else if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = pend_status_ff;
               rsp_slot_in    = tevq_pkg::SLOT_OUT_W'(pend_slot_ff);
               rsp_kind_in    = pend_kind_ff;
               rsp_expiry_in  = pend_expiry_ff;
               rsp_payload_in = tevq_pkg::PAYLOAD_W'(pend_payload_ff);
               rsp_last_in    = 1'b1;
               pend_valid_in  = 1'b0;
               state_in       = tevq_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tevq_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tevq_pkg::ST_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      scan_ff         <= scan_in;
      free_ff         <= free_in;
      cur_ff          <= cur_in;
      prev_ff         <= prev_in;
      have_prev_ff    <= have_prev_in;
      walk_ff         <= walk_in;
      burst_ff        <= burst_in;
      kind_ff         <= kind_in;
      expiry_ff       <= expiry_in;
      payload_ff      <= payload_in;
      now_ff          <= now_in;
      pend_status_ff  <= pend_status_in;
      pend_slot_ff    <= pend_slot_in;
      pend_kind_ff    <= pend_kind_in;
      pend_expiry_ff  <= pend_expiry_in;
      pend_payload_ff <= pend_payload_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_expiry_ff   <= rsp_expiry_in;
      rsp_payload_ff  <= rsp_payload_in;
      rsp_last_ff     <= rsp_last_in;
   end

   // response channel
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.slot           = rsp_slot_ff;
   assign rsp_chan.event_kind_out = rsp_kind_ff;
   assign rsp_chan.expiry_out     = rsp_expiry_ff;
   assign rsp_chan.payload_out    = rsp_payload_ff;
   assign rsp_chan.last           = rsp_last_ff;

   // occupancy never passes the slot count
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("entry count above depth");

   // a free slot always exists while scanning
   a_scan_has_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tevq_pkg::ST_SCAN) |-> (count_ff < COUNT_W'(DEPTH)))
      else $error("free slot scan on a full queue");

   // each pop takes exactly one entry off the list
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      pop_fire |=> (count_ff == $past(count_ff) - COUNT_W'(1)))
      else $error("pop did not reduce entry count");

   // an update never pops more than the burst limit
   a_burst_bound: assert property (@(posedge clock) disable iff (reset)
      pop_fire |-> (burst_ff < BURST_W'(BURST)))
      else $error("burst limit exceeded");

   // an accepted request leaves the idle state
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff != tevq_pkg::ST_IDLE))
      else $error("request accepted without starting work");

endmodule
